// ----- rtl/htfc_pkg.sv -----
// Shared widths, codes and constants for the humidity/temperature frame checker.
package htfc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ValueW  = 15;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CoeffW  = 7;

  // config port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = CoeffW;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCompCoeff  = 2'd0,
    CfgCompEnable = 2'd1
  } cfg_reg_e;

  typedef enum logic [StatusW-1:0] {
    StOk     = 2'd0,
    StBusErr = 2'd1,
    StCrcErr = 2'd2
  } status_e;

  localparam logic signed [CoeffW-1:0] CoeffReset  = -7'sd15;
  localparam logic                     EnableReset = 1'b1;

  // conversion constants, hundredths of a unit
  localparam logic [WordW-1:0] StatusMask = 16'hFFFC;
  localparam int unsigned      TempMul    = 17572;
  localparam int unsigned      TempOffset = 4685;
  localparam int unsigned      HumMul     = 12500;
  localparam int unsigned      HumOffset  = 600;
  localparam int unsigned      CompRef    = 2500;
  localparam int signed        ValueMin   = -6000;
  localparam int signed        ValueMax   = 16000;

  // compensation product width: (2500 - T) * coeff stays within +-664704
  localparam int unsigned ProdW = 22;

  // floor(p / 100) via bias and reciprocal multiply
  localparam int unsigned DivShift   = 28;
  localparam int unsigned DivMulW    = 22;
  localparam int unsigned DivMul     = (1 << DivShift) / 100 + 1;
  localparam int unsigned DivBiasQ   = 7000;
  localparam int unsigned DivBias    = DivBiasQ * 100;

  localparam logic [ByteW-1:0] CrcPoly = 8'h31;

  // bit-serial CRC-8, MSB first, zero init; only used to build constant tables
  function automatic logic [ByteW-1:0] crc8_serial(logic [WordW-1:0] m);
    logic [ByteW-1:0] crc;
    logic             fb;
    crc = '0;
    for (int i = WordW - 1; i >= 0; i--) begin
      fb  = crc[ByteW-1] ^ m[i];
      crc = {crc[ByteW-2:0], 1'b0};
      if (fb) crc = crc ^ CrcPoly;
    end
    return crc;
  endfunction

  // CRC contribution of each single message bit
  function automatic logic [WordW-1:0][ByteW-1:0] crc8_cols();
    logic [WordW-1:0][ByteW-1:0] cols;
    for (int j = 0; j < WordW; j++) begin
      cols[j] = crc8_serial(WordW'(1) << j);
    end
    return cols;
  endfunction

endpackage

// ----- rtl/htfc_crc8.sv -----
// Parallel CRC-8 (poly 0x131, zero init) over a two-byte word.
module htfc_crc8 (
  input  logic [htfc_pkg::WordW-1:0] data_i,
  output logic [htfc_pkg::ByteW-1:0] crc_o
);
  import htfc_pkg::*;

  localparam logic [WordW-1:0][ByteW-1:0] Cols = crc8_cols();

  // CRC is linear: XOR the column of every set bit
  always_comb begin
    crc_o = '0;
    for (int j = 0; j < WordW; j++) begin
      if (data_i[j]) crc_o = crc_o ^ Cols[j];
    end
  end

endmodule

// ----- rtl/htfc_div100.sv -----
// Floored signed divide by 100 of the compensation product.
module htfc_div100 (
  input  logic signed [htfc_pkg::ProdW-1:0]  prod_i,
  output logic signed [htfc_pkg::ValueW-1:0] quot_o
);
  import htfc_pkg::*;

  localparam int unsigned MulW = ProdW + DivMulW;

  logic [ProdW-1:0]  biased;
  logic [MulW-1:0]   scaled;
  logic [ValueW-1:0] quot_u;

  // bias makes the operand non-negative so the reciprocal floor is exact
  assign biased = prod_i + ProdW'(DivBias);
  assign scaled = MulW'(biased) * MulW'(DivMul);
  assign quot_u = ValueW'(scaled >> DivShift);
  assign quot_o = $signed(quot_u - ValueW'(DivBiasQ));

endmodule

// ----- rtl/humidity_temp_frame_check_convert.sv -----
// Top level: sensor reply CRC check, temperature/humidity conversion and compensation.
//
// Takes one three-byte sensor reply per beat and returns one result beat for it, in order.
// Three register stages (input, conversion, compensation/output) lie between input accept
// and result valid, and a new reply is taken every cycle while the output side keeps up.
// The kept temperature is updated as a reply leaves the input stage, so a humidity reply
// right behind a temperature reply already sees the new value.
// Configuration writes are taken at any time (cfg_ready_o is tied high) and should only
// be issued while no reply is in flight.
module humidity_temp_frame_check_convert (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [htfc_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [htfc_pkg::CfgDataW-1:0]          cfg_data_i,
  // reply input
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   func_i,
  input  logic [htfc_pkg::ByteW-1:0]             data_high_i,
  input  logic [htfc_pkg::ByteW-1:0]             data_low_i,
  input  logic [htfc_pkg::ByteW-1:0]             crc_byte_i,
  input  logic                                   read_ok_i,
  // result output
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   kind_o,
  output logic signed [htfc_pkg::ValueW-1:0]     value_o,
  output logic [htfc_pkg::StatusW-1:0]           status_o
);
  import htfc_pkg::*;

  localparam int unsigned TProdW = 31;
  localparam int unsigned HProdW = 30;
  localparam int unsigned SumW   = ValueW + 2;

  // config registers
  logic signed [CoeffW-1:0] coeff_q;
  logic                     comp_en_q;

  // kept temperature
  logic signed [ValueW-1:0] temp_q, temp_d;
  logic                     temp_vld_q, temp_vld_d;

  // input stage
  logic             v0_q;
  logic             func0_q, ok0_q;
  logic [ByteW-1:0] hi0_q, lo0_q, crc0_q;

  // conversion stage
  logic                     v1_q;
  logic                     kind1_q, kind1_d;
  status_e                  status1_q, status1_d;
  logic signed [ValueW-1:0] val1_q, val1_d;
  logic                     comp1_q, comp1_d;
  logic signed [ProdW-1:0]  prod1_q, prod1_d;

  // output stage
  logic                     vo_q;
  logic                     kind_q;
  logic signed [ValueW-1:0] value_q, value_d;
  status_e                  status_q;

  logic rdy0, rdy1, rdy2, adv1;

  assign rdy2       = ~vo_q | out_ready_i;
  assign rdy1       = ~v1_q | rdy2;
  assign rdy0       = ~v0_q | rdy1;
  assign adv1       = v0_q & rdy1;
  assign in_ready_o = rdy0;
  assign cfg_ready_o = 1'b1;

  // ---------------- config ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q   <= CoeffReset;
      comp_en_q <= EnableReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgCompCoeff:  coeff_q   <= $signed(cfg_data_i[CoeffW-1:0]);
        CfgCompEnable: comp_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy0) begin
      func0_q <= func_i;
      hi0_q   <= data_high_i;
      lo0_q   <= data_low_i;
      crc0_q  <= crc_byte_i;
      ok0_q   <= read_ok_i;
    end
  end

  // ---------------- conversion ----------------
  logic [WordW-1:0]          word0, raw0;
  logic [ByteW-1:0]          crc_calc;
  logic [TProdW-1:0]         t_prod;
  logic [HProdW-1:0]         h_prod;
  logic signed [WordW-1:0]   t_full, h_full, diff;
  logic signed [ProdW:0]     prod_full;

  assign word0 = {hi0_q, lo0_q};
  assign raw0  = word0 & StatusMask;

  htfc_crc8 u_crc8 (
    .data_i (word0),
    .crc_o  (crc_calc)
  );

  assign t_prod = TProdW'(raw0) * TProdW'(TempMul);
  assign h_prod = HProdW'(raw0) * HProdW'(HumMul);
  assign t_full = $signed({1'b0, t_prod[TProdW-1:WordW]}) - $signed(WordW'(TempOffset));
  assign h_full = $signed({2'b0, h_prod[HProdW-1:WordW]}) - $signed(WordW'(HumOffset));

  // compensation product uses the kept temperature
  assign diff      = $signed(WordW'(CompRef)) - $signed({temp_q[ValueW-1], temp_q});
  assign prod_full = diff * coeff_q;
  assign prod1_d   = prod_full[ProdW-1:0];

  always_comb begin
    kind1_d    = func0_q;
    status1_d  = StOk;
    val1_d     = '0;
    comp1_d    = 1'b0;
    temp_d     = temp_q;
    temp_vld_d = temp_vld_q;
    if (!ok0_q) begin
      status1_d = StBusErr;
    end else if (crc_calc != crc0_q) begin
      status1_d = StCrcErr;
    end
    if (status1_d == StOk) begin
      if (!func0_q) begin
        val1_d     = t_full[ValueW-1:0];
        temp_d     = t_full[ValueW-1:0];
        temp_vld_d = 1'b1;
      end else begin
        val1_d  = h_full[ValueW-1:0];
        comp1_d = comp_en_q & temp_vld_q;
      end
    end else if (!func0_q) begin
      temp_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q     <= '0;
      temp_vld_q <= 1'b0;
      v1_q       <= 1'b0;
    end else begin
      if (adv1) begin
        temp_q     <= temp_d;
        temp_vld_q <= temp_vld_d;
      end
      if (rdy1) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      kind1_q   <= kind1_d;
      status1_q <= status1_d;
      val1_q    <= val1_d;
      comp1_q   <= comp1_d;
      prod1_q   <= prod1_d;
    end
  end

  // ---------------- compensation ----------------
  logic signed [ValueW-1:0] comp_term;
  logic signed [SumW-1:0]   sum;

  htfc_div100 u_div100 (
    .prod_i (prod1_q),
    .quot_o (comp_term)
  );

  assign sum = SumW'(val1_q) + SumW'(comp_term);

  always_comb begin
    value_d = val1_q;
    if (comp1_q) begin
      if (sum > SumW'(ValueMax)) begin
        value_d = ValueW'(ValueMax);
      end else if (sum < SumW'(ValueMin)) begin
        value_d = ValueW'(ValueMin);
      end else begin
        value_d = sum[ValueW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy2) begin
      vo_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      kind_q   <= kind1_q;
      value_q  <= value_d;
      status_q <= status1_q;
    end
  end

  assign out_valid_o = vo_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign status_o    = status_q;

endmodule
